>>> hdl/point_rotate_degrees_macros.svh
// Assertion helpers shared by the point rotation block.
// Each macro expects clk and rst_n in scope and is idle while reset is low.
`ifndef POINT_ROTATE_DEGREES_MACROS_SVH
`define POINT_ROTATE_DEGREES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point_rotate_degrees: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point_rotate_degrees: next-cycle check failed");

`endif

>>> hdl/prd_pkg.sv
package prd_pkg;

  // Field widths of the channels.
  localparam int XY_W  = 32;
  localparam int ANG_W = 26;

  // Algorithm settings.
  localparam int CORDIC_STEPS = 24;
  localparam int FRAC_BITS    = 16;
  localparam int N_STEPS      = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int STEP_W       = 5;

  // Angle units: one full turn and one quarter turn in 1/65536 degree.
  localparam int TURN_UNITS    = 23592960;
  localparam int QUARTER_UNITS = 5898240;
  localparam int AE_W          = ANG_W + 1;
  localparam int R_W           = 25;
  localparam int RES_W         = 23;

  // Residual to binary angle: z = (res * 8192 + 22) / 45.
  // res is split as 45 * m + t, so z = m * 8192 + (t * 8192 + 22) / 45.
  localparam int ANG_DIV   = 45;
  localparam int ANG_SH    = 13;
  localparam int ANG_BIAS  = 22;
  localparam int RECIP     = 11930465;
  localparam int RECIP_W   = 24;
  localparam int RECIP_SH  = 29;
  localparam int PD_W      = RES_W + RECIP_W;
  localparam int M_W       = 17;
  localparam int TI_W      = 6;

  // CORDIC datapath.
  localparam int TRIG_FRAC = 30;
  localparam int GAIN_Q30  = 652032874;
  localparam int CX_W      = 34;
  localparam int Z_W       = 34;

  // Rounded trig values and product widths.
  localparam int CS_SH = TRIG_FRAC - FRAC_BITS;
  localparam int CS_W  = FRAC_BITS + 3;
  localparam int PR_W  = XY_W + CS_W;
  localparam int SM_W  = PR_W + 1;

  // atan(2^-i) as a binary angle, 2^32 per turn.
  localparam int ATAN_TAB [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0
  };

  // Fraction part of the binary angle for each remainder t below 45.
  typedef logic [ANG_SH-1:0] ztab_t [2**TI_W];

  function automatic ztab_t make_ztab();
    ztab_t tab;
    for (int i = 0; i < 2**TI_W; i++) begin
      if (i < ANG_DIV) begin
        tab[i] = ANG_SH'((i * (2**ANG_SH) + ANG_BIAS) / ANG_DIV);
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

  localparam ztab_t ZTAB = make_ztab();

  // Quadrant of the reduced angle.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Request moving down the CORDIC chain.
  typedef struct packed {
    logic signed [XY_W-1:0] px;
    logic signed [XY_W-1:0] py;
    quad_t                  q;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
  } cell_t;

endpackage

>>> hdl/prd_in_if.sv
interface prd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [prd_pkg::XY_W-1:0]       in_x;
  logic signed [prd_pkg::XY_W-1:0]       in_y;
  logic signed [prd_pkg::ANG_W-1:0]      angle_deg;

  modport source (output valid, output in_x, output in_y, output angle_deg, input ready);
  modport sink (input valid, input in_x, input in_y, input angle_deg, output ready);
endinterface

>>> hdl/prd_out_if.sv
interface prd_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [prd_pkg::XY_W-1:0] rot_x;
  logic signed [prd_pkg::XY_W-1:0] rot_y;
  logic                            clipped;

  modport source (output valid, output rot_x, output rot_y, output clipped, input ready);
  modport sink (input valid, input rot_x, input rot_y, input clipped, output ready);
endinterface

>>> hdl/prd_angle_reduce.sv
`include "point_rotate_degrees_macros.svh"

module prd_angle_reduce (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [prd_pkg::XY_W-1:0]  up_x,
  input  logic signed [prd_pkg::XY_W-1:0]  up_y,
  input  logic signed [prd_pkg::ANG_W-1:0] up_ang,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output prd_pkg::cell_t                   dn
);

  localparam int NST = 4;

  localparam logic signed [prd_pkg::AE_W-1:0] TURN_S =
    prd_pkg::AE_W'(prd_pkg::TURN_UNITS);
  localparam logic [prd_pkg::R_W-1:0] Q1 = prd_pkg::R_W'(prd_pkg::QUARTER_UNITS);
  localparam logic [prd_pkg::R_W-1:0] Q2 = prd_pkg::R_W'(2 * prd_pkg::QUARTER_UNITS);
  localparam logic [prd_pkg::R_W-1:0] Q3 = prd_pkg::R_W'(3 * prd_pkg::QUARTER_UNITS);
  localparam logic [prd_pkg::RES_W-1:0] DIV_C = prd_pkg::RES_W'(prd_pkg::ANG_DIV);

  logic [NST-1:0] v_r;
  logic [NST:0]   ld;

  logic signed [prd_pkg::XY_W-1:0] px_r [NST-1];
  logic signed [prd_pkg::XY_W-1:0] py_r [NST-1];

  logic [prd_pkg::R_W-1:0]    r_r, r_nxt;
  prd_pkg::quad_t             q2_r, q3_r, q_nxt;
  logic [prd_pkg::RES_W-1:0]  res2_r, res3_r, res_nxt;
  logic [prd_pkg::PD_W-1:0]   prod_r, prod_nxt;
  prd_pkg::cell_t             dn_r, dn_nxt;

  logic signed [prd_pkg::AE_W-1:0] a_e, a_p1, a_p2, a_m1, a_sel;
  logic [prd_pkg::M_W-1:0]         m_est, m_fix;
  logic [prd_pkg::RES_W-1:0]       t_raw, t_fix;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    ld[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[NST-1];
  assign dn       = dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: reduce the angle into one turn.
  always_comb begin
    a_e  = prd_pkg::AE_W'(up_ang);
    a_p1 = a_e + TURN_S;
    a_p2 = a_p1 + TURN_S;
    a_m1 = a_e - TURN_S;
    if (a_e < 0) begin
      a_sel = (a_p1 < 0) ? a_p2 : a_p1;
    end else begin
      a_sel = (a_e >= TURN_S) ? a_m1 : a_e;
    end
    r_nxt = a_sel[prd_pkg::R_W-1:0];
  end

  // Stage 2: split into a quadrant and a residual below a quarter turn.
  always_comb begin
    if (r_r >= Q3) begin
      q_nxt   = prd_pkg::QUAD_3;
      res_nxt = prd_pkg::RES_W'(r_r - Q3);
    end else if (r_r >= Q2) begin
      q_nxt   = prd_pkg::QUAD_2;
      res_nxt = prd_pkg::RES_W'(r_r - Q2);
    end else if (r_r >= Q1) begin
      q_nxt   = prd_pkg::QUAD_1;
      res_nxt = prd_pkg::RES_W'(r_r - Q1);
    end else begin
      q_nxt   = prd_pkg::QUAD_0;
      res_nxt = prd_pkg::RES_W'(r_r);
    end
  end

  // Stage 3: quotient by 45 through the reciprocal.
  assign prod_nxt = prd_pkg::PD_W'(res2_r) * prd_pkg::PD_W'(prd_pkg::RECIP);

  // Stage 4: remainder, correction and the binary angle.
  always_comb begin
    m_est = prod_r[prd_pkg::RECIP_SH +: prd_pkg::M_W];
    t_raw = res3_r - prd_pkg::RES_W'(m_est * prd_pkg::ANG_DIV);
    if (t_raw >= DIV_C) begin
      m_fix = m_est + 1'b1;
      t_fix = t_raw - DIV_C;
    end else begin
      m_fix = m_est;
      t_fix = t_raw;
    end
    dn_nxt.px = px_r[2];
    dn_nxt.py = py_r[2];
    dn_nxt.q  = q3_r;
    dn_nxt.cx = prd_pkg::CX_W'(prd_pkg::GAIN_Q30);
    dn_nxt.cy = '0;
    dn_nxt.z  = prd_pkg::Z_W'({m_fix, prd_pkg::ZTAB[t_fix[prd_pkg::TI_W-1:0]]});
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      px_r[0] <= up_x;
      py_r[0] <= up_y;
      r_r     <= r_nxt;
    end
    if (ld[1]) begin
      px_r[1] <= px_r[0];
      py_r[1] <= py_r[0];
      q2_r    <= q_nxt;
      res2_r  <= res_nxt;
    end
    if (ld[2]) begin
      px_r[2] <= px_r[1];
      py_r[2] <= py_r[1];
      q3_r    <= q2_r;
      res3_r  <= res2_r;
      prod_r  <= prod_nxt;
    end
    if (ld[3]) begin
      dn_r <= dn_nxt;
    end
  end

  `PRD_ASSERT_NOW(a_turn_range, v_r[0], r_r < prd_pkg::R_W'(prd_pkg::TURN_UNITS))
  `PRD_ASSERT_NOW(a_quarter_range, v_r[1], res2_r < Q1)
  `PRD_ASSERT_NOW(a_recip_exact, v_r[2], t_raw < DIV_C)

endmodule

>>> hdl/prd_cordic_cell.sv
module prd_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [prd_pkg::STEP_W-1:0]  step,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  prd_pkg::cell_t              up,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output prd_pkg::cell_t              dn
);

  logic           v_r;
  logic           ld;
  prd_pkg::cell_t dn_r, dn_nxt;

  logic signed [prd_pkg::CX_W-1:0] dx, dy;
  logic signed [prd_pkg::Z_W-1:0]  at;

  assign ld       = !v_r || dn_ready;
  assign up_ready = ld;
  assign dn_valid = v_r;
  assign dn       = dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= up_valid;
    end
  end

  // One rotation step: turn toward zero residual angle.
  always_comb begin
    dx     = up.cy >>> step;
    dy     = up.cx >>> step;
    at     = prd_pkg::Z_W'(prd_pkg::ATAN_TAB[step]);
    dn_nxt = up;
    if (!up.z[prd_pkg::Z_W-1]) begin
      dn_nxt.cx = up.cx - dx;
      dn_nxt.cy = up.cy + dy;
      dn_nxt.z  = up.z - at;
    end else begin
      dn_nxt.cx = up.cx + dx;
      dn_nxt.cy = up.cy - dy;
      dn_nxt.z  = up.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dn_r <= dn_nxt;
    end
  end

endmodule

>>> hdl/prd_mix.sv
`include "point_rotate_degrees_macros.svh"

module prd_mix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  prd_pkg::cell_t                  up,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic signed [prd_pkg::XY_W-1:0] rot_x,
  output logic signed [prd_pkg::XY_W-1:0] rot_y,
  output logic                            clipped
);

  localparam int NST = 3;

  localparam logic signed [prd_pkg::CX_W-1:0] CS_HALF =
    prd_pkg::CX_W'(64'sd1 <<< (prd_pkg::CS_SH - 1));
  localparam logic signed [prd_pkg::SM_W-1:0] XY_HALF =
    prd_pkg::SM_W'(64'sd1 <<< (prd_pkg::FRAC_BITS - 1));
  localparam logic signed [prd_pkg::SM_W-1:0] SAT_HI = prd_pkg::SM_W'(64'sd2147483647);
  localparam logic signed [prd_pkg::SM_W-1:0] SAT_LO = prd_pkg::SM_W'(-64'sd2147483648);
  localparam logic signed [prd_pkg::XY_W-1:0] OUT_HI = prd_pkg::XY_W'(64'sd2147483647);
  localparam logic signed [prd_pkg::XY_W-1:0] OUT_LO = prd_pkg::XY_W'(-64'sd2147483648);

  logic [NST-1:0] v_r;
  logic [NST:0]   ld;

  logic signed [prd_pkg::XY_W-1:0] px_r, py_r;
  logic signed [prd_pkg::CS_W-1:0] c_r, s_r, c_nxt, s_nxt;
  logic signed [prd_pkg::CX_W-1:0] c_sel, s_sel, c_rnd, s_rnd;
  logic signed [prd_pkg::PR_W-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [prd_pkg::SM_W-1:0] nx_sum, ny_sum, nx_sh, ny_sh;
  logic signed [prd_pkg::XY_W-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic                            clip_r, clip_nxt;
  logic                            x_hi, x_lo, y_hi, y_lo;

  always_comb begin
    ld[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[NST-1];
  assign rot_x    = rx_r;
  assign rot_y    = ry_r;
  assign clipped  = clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: apply the quadrant, then round cos and sin to the point format.
  always_comb begin
    case (up.q)
      prd_pkg::QUAD_0: begin
        c_sel = up.cx;
        s_sel = up.cy;
      end
      prd_pkg::QUAD_1: begin
        c_sel = -up.cy;
        s_sel = up.cx;
      end
      prd_pkg::QUAD_2: begin
        c_sel = -up.cx;
        s_sel = -up.cy;
      end
      prd_pkg::QUAD_3: begin
        c_sel = up.cy;
        s_sel = -up.cx;
      end
      default: begin
        c_sel = up.cx;
        s_sel = up.cy;
      end
    endcase
    c_rnd = (c_sel + CS_HALF) >>> prd_pkg::CS_SH;
    s_rnd = (s_sel + CS_HALF) >>> prd_pkg::CS_SH;
    c_nxt = c_rnd[prd_pkg::CS_W-1:0];
    s_nxt = s_rnd[prd_pkg::CS_W-1:0];
  end

  // Stage 3: sums, rounding and saturation.
  always_comb begin
    nx_sum   = prd_pkg::SM_W'(pxc_r) - prd_pkg::SM_W'(pys_r) + XY_HALF;
    ny_sum   = prd_pkg::SM_W'(pxs_r) + prd_pkg::SM_W'(pyc_r) + XY_HALF;
    nx_sh    = nx_sum >>> prd_pkg::FRAC_BITS;
    ny_sh    = ny_sum >>> prd_pkg::FRAC_BITS;
    x_hi     = nx_sh > SAT_HI;
    x_lo     = nx_sh < SAT_LO;
    y_hi     = ny_sh > SAT_HI;
    y_lo     = ny_sh < SAT_LO;
    rx_nxt   = x_hi ? OUT_HI : (x_lo ? OUT_LO : nx_sh[prd_pkg::XY_W-1:0]);
    ry_nxt   = y_hi ? OUT_HI : (y_lo ? OUT_LO : ny_sh[prd_pkg::XY_W-1:0]);
    clip_nxt = x_hi || x_lo || y_hi || y_lo;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      px_r <= up.px;
      py_r <= up.py;
      c_r  <= c_nxt;
      s_r  <= s_nxt;
    end
    // Stage 2: the four products.
    if (ld[1]) begin
      pxc_r <= prd_pkg::PR_W'(px_r) * prd_pkg::PR_W'(c_r);
      pys_r <= prd_pkg::PR_W'(py_r) * prd_pkg::PR_W'(s_r);
      pxs_r <= prd_pkg::PR_W'(px_r) * prd_pkg::PR_W'(s_r);
      pyc_r <= prd_pkg::PR_W'(py_r) * prd_pkg::PR_W'(c_r);
    end
    if (ld[2]) begin
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      clip_r <= clip_nxt;
    end
  end

  `PRD_ASSERT_NOW(a_clip_at_bound, v_r[2] && clip_r,
    rx_r == OUT_HI || rx_r == OUT_LO || ry_r == OUT_HI || ry_r == OUT_LO)

endmodule

>>> hdl/point_rotate_degrees.sv
// Rotates a stream of 2-D points about the origin by an angle in degrees.
// Input channel in_ch carries in_x, in_y (signed Q16.16) and angle_deg
// (1/65536 degree, counterclockwise); a request is taken when valid and
// ready are both high. Output channel out_ch returns rot_x, rot_y (Q16.16,
// saturated) and clipped, one result per request, in order.
// The block is a pipeline: four stages of angle reduction, one CORDIC cell
// per iteration (24 by default), then three stages that apply the quadrant,
// multiply and round. Throughput is one request per cycle while the receiver
// takes results. Every stage holds its own valid bit and loads when it is
// empty or its content moves on, so a stalled receiver only stops the stages
// that are full; in_ch.ready falls once the whole pipeline is full behind a
// stalled result. A held result stays stable until taken.
// Synchronous active-low reset empties all stages; no result is issued
// during reset.
`include "point_rotate_degrees_macros.svh"

module point_rotate_degrees (
  input  logic       clk,
  input  logic       rst_n,
  prd_in_if.sink     in_ch,
  prd_out_if.source  out_ch
);

  localparam int N = prd_pkg::N_STEPS;

  prd_pkg::cell_t lnk     [N+1];
  logic           lnk_v   [N+1];
  logic           lnk_rdy [N+1];

  // Angle reduction and binary angle conversion.
  prd_angle_reduce u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_x     (in_ch.in_x),
    .up_y     (in_ch.in_y),
    .up_ang   (in_ch.angle_deg),
    .dn_valid (lnk_v[0]),
    .dn_ready (lnk_rdy[0]),
    .dn       (lnk[0])
  );

  // Row of CORDIC cells, one iteration each.
  for (genvar i = 0; i < N; i++) begin : g_cell
    prd_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (prd_pkg::STEP_W'(i)),
      .up_valid (lnk_v[i]),
      .up_ready (lnk_rdy[i]),
      .up       (lnk[i]),
      .dn_valid (lnk_v[i+1]),
      .dn_ready (lnk_rdy[i+1]),
      .dn       (lnk[i+1])
    );
  end

  // Quadrant, products, rounding and saturation.
  prd_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lnk_v[N]),
    .up_ready (lnk_rdy[N]),
    .up       (lnk[N]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .rot_x    (out_ch.rot_x),
    .rot_y    (out_ch.rot_y),
    .clipped  (out_ch.clipped)
  );

  `PRD_ASSERT_NOW(a_full_stall, !in_ch.ready, out_ch.valid && !out_ch.ready)

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Angle units are 1/65536 degree.
  localparam longint FULL_TURN    = 360 * 65536;
  localparam longint QUARTER_TURN = 90 * 65536;
  localparam int     ONE_DEG      = 65536;
  localparam longint ONE_Q16      = 65536;
  localparam int     TRIG_Q       = 30;
  localparam longint UNIT_GAIN    = 652032874;
  localparam int     ROT_STEPS    =
    (prd_pkg::CORDIC_STEPS > 32) ? 32 : prd_pkg::CORDIC_STEPS;
  localparam int     DRAIN_CYCLES = 7 + prd_pkg::CORDIC_STEPS + 16;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     RAND_PER_PHASE = 488;

  // atan(2^-i) as a binary angle with 2^32 per turn.
  localparam longint ARCTAN_TURN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0
  };

  typedef struct {
    logic signed [prd_pkg::XY_W-1:0]  x;
    logic signed [prd_pkg::XY_W-1:0]  y;
    logic signed [prd_pkg::ANG_W-1:0] ang;
  } point_req_t;

  typedef struct {
    logic signed [prd_pkg::XY_W-1:0] x;
    logic signed [prd_pkg::XY_W-1:0] y;
    logic                            clip;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side copies of every block input, known from time zero.
  logic                             drv_valid = 1'b0;
  logic signed [prd_pkg::XY_W-1:0]  drv_x     = '0;
  logic signed [prd_pkg::XY_W-1:0]  drv_y     = '0;
  logic signed [prd_pkg::ANG_W-1:0] drv_ang   = '0;
  logic                             drv_ready = 1'b0;

  point_req_t  point_q[$];
  rot_result_t rot_expect_q[$];
  point_req_t  next_req;
  logic        req_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          err_count = 0;
  int          cycle_count = 0;

  prd_in_if  in_ch ();
  prd_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.in_x      = drv_x;
  assign in_ch.in_y      = drv_y;
  assign in_ch.angle_deg = drv_ang;
  assign out_ch.ready    = drv_ready;

  point_rotate_degrees uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounds half up by sh fraction bits; >>> floors like the hardware.
  function automatic longint round_half_up(longint v, int sh);
    if (sh <= 0) begin
      return v;
    end
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp32(longint v, inout logic hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Expected rotation of one point: angle reduction, CORDIC, quadrant, products.
  function automatic rot_result_t rotate_point(point_req_t req);
    longint         px, py, ang, red, res, z, cx, cy, dx, dy, c, s, nx, ny;
    prd_pkg::quad_t quad;
    logic           hit;
    rot_result_t    r;
    px  = longint'(req.x);
    py  = longint'(req.y);
    ang = longint'(req.ang);
    red = ang % FULL_TURN;
    if (red < 0) begin
      red = red + FULL_TURN;
    end
    quad = prd_pkg::quad_t'(2'(red / QUARTER_TURN));
    res  = red - (red / QUARTER_TURN) * QUARTER_TURN;
    z    = (res * 8192 + 22) / 45;

    // Rotation mode from the gain-compensated unit vector.
    cx = UNIT_GAIN;
    cy = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - ARCTAN_TURN[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + ARCTAN_TURN[i];
      end
    end

    case (quad)
      prd_pkg::QUAD_0: begin
        c = cx;
        s = cy;
      end
      prd_pkg::QUAD_1: begin
        c = -cy;
        s = cx;
      end
      prd_pkg::QUAD_2: begin
        c = -cx;
        s = -cy;
      end
      default: begin
        c = cy;
        s = -cx;
      end
    endcase
    c = round_half_up(c, TRIG_Q - prd_pkg::FRAC_BITS);
    s = round_half_up(s, TRIG_Q - prd_pkg::FRAC_BITS);

    nx  = round_half_up(px * c - py * s, prd_pkg::FRAC_BITS);
    ny  = round_half_up(px * s + py * c, prd_pkg::FRAC_BITS);
    hit = 1'b0;
    nx  = clamp32(nx, hit);
    ny  = clamp32(ny, hit);
    r.x    = nx[prd_pkg::XY_W-1:0];
    r.y    = ny[prd_pkg::XY_W-1:0];
    r.clip = hit;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic push_point(longint x, longint y, longint ang);
    point_req_t req;
    req.x   = x[prd_pkg::XY_W-1:0];
    req.y   = y[prd_pkg::XY_W-1:0];
    req.ang = ang[prd_pkg::ANG_W-1:0];
    point_q.push_back(req);
  endtask

  task automatic ny_swap(inout longint a, inout longint b);
    longint t;
    t = a;
    a = b;
    b = t;
  endtask

  // Random point: mostly moderate coordinates, some full range and extremes.
  task automatic push_random_point();
    int     kind;
    int     akind;
    longint x, y, ang;
    kind  = $urandom_range(9);
    akind = $urandom_range(9);
    if (kind <= 2) begin
      x = longint'($signed($urandom));
      y = longint'($signed($urandom));
    end else if (kind <= 7) begin
      x = longint'($signed($urandom) >>> $urandom_range(31, 6));
      y = longint'($signed($urandom) >>> $urandom_range(31, 6));
    end else begin
      x = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
      y = longint'($signed($urandom));
      if ($urandom_range(1)) begin
        ny_swap(x, y);
      end
    end
    if (akind <= 5) begin
      ang = longint'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
    end else if (akind <= 7) begin
      ang = (longint'($urandom_range(8)) - 4) * QUARTER_TURN
            + longint'($urandom_range(8)) - 4;
    end else begin
      ang = longint'($signed(26'($urandom)));
    end
    push_point(x, y, ang);
  endtask

  // Sender pauses until every request has been taken and answered.
  task automatic wait_drained();
    while (point_q.size() != 0 || drv_valid || rot_expect_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic next_req_pred();
    point_req_t req;
    req.x   = in_ch.in_x;
    req.y   = in_ch.in_y;
    req.ang = in_ch.angle_deg;
    rot_expect_q.push_back(rotate_point(req));
  endtask

  task automatic check_result();
    rot_result_t want;
    if (rot_expect_q.size() == 0) begin
      report_mismatch("unexpected result rot_x", longint'(out_ch.rot_x), 0);
    end else begin
      want = rot_expect_q.pop_front();
      if (out_ch.rot_x !== want.x) begin
        report_mismatch("rot_x", longint'(out_ch.rot_x), longint'(want.x));
      end
      if (out_ch.rot_y !== want.y) begin
        report_mismatch("rot_y", longint'(out_ch.rot_y), longint'(want.y));
      end
      if (out_ch.clipped !== want.clip) begin
        report_mismatch("clipped", longint'(out_ch.clipped), longint'(want.clip));
      end
    end
  endtask

  // Request driver: holds a request until taken, idles at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || req_taken) begin
      if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = point_q.pop_front();
        drv_valid <= 1'b1;
        drv_x     <= next_req.x;
        drv_y     <= next_req.y;
        drv_ang   <= next_req.ang;
      end else begin
        drv_valid <= 1'b0;
      end
    end
    drv_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on each taken request, checks each taken result.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        next_req_pred();
      end
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL point_rotate_degrees");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests run with no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_point(ONE_Q16, 0, 0);
    push_point(ONE_Q16, 0, QUARTER_TURN);
    push_point(ONE_Q16, 0, 2 * QUARTER_TURN);
    push_point(ONE_Q16, 0, 3 * QUARTER_TURN);
    push_point(0, ONE_Q16, 45 * ONE_DEG);
    push_point(64'sd2147483647, 64'sd2147483647, 45 * ONE_DEG);
    push_point(-64'sd2147483648, -64'sd2147483648, 45 * ONE_DEG);
    push_point(-64'sd2147483648, 0, 2 * QUARTER_TURN);
    push_point(64'sd2147483647, -64'sd2147483648, 0);
    push_point(-64'sd2147483648, 64'sd2147483647, QUARTER_TURN);
    push_point(229376, -147456, FULL_TURN);
    push_point(229376, -147456, -FULL_TURN);
    push_point(229376, -147456, -QUARTER_TURN);
    push_point(ONE_Q16, ONE_Q16, 33554431);
    push_point(ONE_Q16, ONE_Q16, -33554432);
    push_point(ONE_Q16, ONE_Q16, 1);
    push_point(ONE_Q16, ONE_Q16, QUARTER_TURN - 1);
    push_point(ONE_Q16, ONE_Q16, FULL_TURN - 1);
    push_point(ONE_Q16, ONE_Q16, -1);
    push_point(0, 0, 30 * ONE_DEG);
    push_point(64'sh55555555, -64'sh55555556, 8090812);
    push_point(-1, -1, 7 * ONE_DEG);

    // Random phases: none, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        push_random_point();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && rot_expect_q.size() == 0) begin
      $display("PASS point_rotate_degrees");
    end else begin
      $display("FAIL point_rotate_degrees");
    end
    $finish;
  end

endmodule
